### design/ccs_pkg.sv
// shared types, constants and register codes for the complex convolution unit
// depends on nothing; used by every module of the block by scoped names
`default_nettype none
package ccs_pkg;

    // default sizes
    localparam int MAX_TAPS_DEF = 32;
    localparam int MAX_LEN_DEF  = 65536;

    // fixed field widths
    localparam int SAMPLE_BITS = 16;
    localparam int TAP_CNT_W   = 6;
    localparam int SHAPE_W     = 2;
    localparam int TAP_IDX_W   = 5;
    localparam int ACC_W       = 40;
    localparam int POS_W       = 17;
    localparam int PROD_W      = 2 * SAMPLE_BITS;
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_IDX_W   = 1;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_MODE = 1'd1;

    // output window codes
    localparam logic [SHAPE_W-1:0] SHAPE_FULL  = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_SAME  = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_VALID = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
    } t_cplx;

    // one classified item in the queue
    typedef struct packed {
        logic                 is_sample;
        logic                 tap_ok;
        logic [TAP_IDX_W-1:0] tap_index;
        t_cplx                value;
        logic                 last;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_INIT,
        ST_MAC,
        ST_DRAIN,
        ST_OUT,
        ST_FIN
    } t_state;

endpackage
`default_nettype wire

### design/complex_convolution_shaped_unit.sv
// top level of the complex convolution unit: configuration registers,
// front queue and back sequencer; depends on ccs_pkg, ccs_front, ccs_back
//
// usage: items arrive on the input channel (i_valid / o_stall). action 0
// writes one kernel tap, action 1 pushes one complex sample of a vector;
// sample_last closes the vector and flushes its tail outputs. results leave
// on the output channel (o_valid / i_stall), one per convolution output of
// the window picked by shape_mode, with vector_done on the vector's last one.
// a two-entry queue takes items while the back end works.
// sequence: a tap load leaves the queue while the sequencer is idle. a sample
// passes setup, then, per output at delay d, init, a mac pass over taps d to
// L2 - 1, drain and output, then a finish state, where L2 is the taps in use;
// the single shared complex mac serves them all, and items leave the queue only in idle.
// a stalled result holds in the output register and the sequencer waits.
// reset clears the kernel, history, vector counters and queue; tap_count returns
// to 1 and shape_mode to full. configure only while the block is idle.
`default_nettype none
module complex_convolution_shaped_unit #(
    parameter int MAX_TAPS = ccs_pkg::MAX_TAPS_DEF,
    parameter int MAX_LEN  = ccs_pkg::MAX_LEN_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire [ccs_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire [ccs_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  wire                                   i_valid,
    output logic                                  o_stall,
    input  wire                                   i_action,
    input  wire [ccs_pkg::TAP_IDX_W-1:0]          i_tap_index,
    input  wire signed [ccs_pkg::SAMPLE_BITS-1:0] i_value_re,
    input  wire signed [ccs_pkg::SAMPLE_BITS-1:0] i_value_im,
    input  wire                                   i_sample_last,
    output logic                                  o_valid,
    input  wire                                   i_stall,
    output logic signed [ccs_pkg::ACC_W-1:0]      o_out_re,
    output logic signed [ccs_pkg::ACC_W-1:0]      o_out_im,
    output logic [ccs_pkg::POS_W-1:0]             o_out_position,
    output logic                                  o_vector_done
);

    logic [ccs_pkg::TAP_CNT_W-1:0] r_tap_count;
    logic [ccs_pkg::SHAPE_W-1:0]   r_shape_mode;
    logic                          w_q_valid, w_q_pop;
    ccs_pkg::t_item                w_q_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count  <= ccs_pkg::TAP_CNT_W'(1);
            r_shape_mode <= ccs_pkg::SHAPE_FULL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ccs_pkg::CFG_TAP_COUNT:  r_tap_count  <= i_cfg_data;
                ccs_pkg::CFG_SHAPE_MODE: r_shape_mode <= i_cfg_data[ccs_pkg::SHAPE_W-1:0];
                default: ;
            endcase
        end
    end

    // front: accept and queue
    ccs_front #(.MAX_TAPS(MAX_TAPS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_tap_index   (i_tap_index),
        .i_value_re    (i_value_re),
        .i_value_im    (i_value_im),
        .i_sample_last (i_sample_last),
        .o_q_valid     (w_q_valid),
        .o_q_item      (w_q_item),
        .i_q_pop       (w_q_pop)
    );

    // back: convolution sequencer
    ccs_back #(.MAX_TAPS(MAX_TAPS), .MAX_LEN(MAX_LEN)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tap_count    (r_tap_count),
        .i_shape_mode   (r_shape_mode),
        .i_q_valid      (w_q_valid),
        .i_q_item       (w_q_item),
        .o_q_pop        (w_q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_re       (o_out_re),
        .o_out_im       (o_out_im),
        .o_out_position (o_out_position),
        .o_vector_done  (o_vector_done)
    );

    // checks
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid) else $error("queue popped while empty");
    a_no_pop_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !w_q_pop) else $error("item taken while a result is pending");
    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_position)))
        else $error("stalled result lost");

endmodule
`default_nettype wire

### design/ccs_front.sv
// front end: accepts items, classifies them and holds them in a short queue
// depends on ccs_pkg
`default_nettype none
module ccs_front #(
    parameter int MAX_TAPS = ccs_pkg::MAX_TAPS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire                              i_action,
    input  wire [ccs_pkg::TAP_IDX_W-1:0]     i_tap_index,
    input  wire signed [ccs_pkg::SAMPLE_BITS-1:0] i_value_re,
    input  wire signed [ccs_pkg::SAMPLE_BITS-1:0] i_value_im,
    input  wire                              i_sample_last,
    output logic                             o_q_valid,
    output ccs_pkg::t_item                   o_q_item,
    input  wire                              i_q_pop
);

    ccs_pkg::t_item                r_buf [ccs_pkg::Q_DEPTH];
    logic [ccs_pkg::Q_AW-1:0]      r_wr_ptr, r_rd_ptr;
    logic [ccs_pkg::Q_AW:0]        r_count;
    ccs_pkg::t_item                w_item;
    logic                          w_push;

    // classify the incoming item
    always_comb begin
        w_item.is_sample = i_action;
        w_item.tap_ok    = (32'(i_tap_index) < MAX_TAPS);
        w_item.tap_index = i_tap_index;
        w_item.value.re  = i_value_re;
        w_item.value.im  = i_value_im;
        w_item.last      = i_sample_last;
    end

    assign o_stall   = (r_count == (ccs_pkg::Q_AW + 1)'(ccs_pkg::Q_DEPTH));
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_buf[r_rd_ptr];

    // queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_q_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({w_push, i_q_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_buf[r_wr_ptr] <= w_item;
    end

endmodule
`default_nettype wire

### design/ccs_back.sv
// back end: kernel store, sample history, window sequencer and complex mac
// depends on ccs_pkg
`default_nettype none
module ccs_back #(
    parameter int MAX_TAPS = ccs_pkg::MAX_TAPS_DEF,
    parameter int MAX_LEN  = ccs_pkg::MAX_LEN_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire [ccs_pkg::TAP_CNT_W-1:0]       i_tap_count,
    input  wire [ccs_pkg::SHAPE_W-1:0]         i_shape_mode,
    input  wire                                i_q_valid,
    input  ccs_pkg::t_item                     i_q_item,
    output logic                               o_q_pop,
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic signed [ccs_pkg::ACC_W-1:0]   o_out_re,
    output logic signed [ccs_pkg::ACC_W-1:0]   o_out_im,
    output logic [ccs_pkg::POS_W-1:0]          o_out_position,
    output logic                               o_vector_done
);

    localparam int TW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int LW = $clog2(MAX_TAPS + 1);
    localparam int SW = $clog2(MAX_LEN + 1);
    localparam int NW = $clog2(MAX_LEN + MAX_TAPS + 1);
    localparam int PW = ccs_pkg::PROD_W;
    localparam int AW = ccs_pkg::ACC_W;

    ccs_pkg::t_state r_state, n_state;

    ccs_pkg::t_cplx  r_kern [MAX_TAPS];
    ccs_pkg::t_cplx  r_hist [MAX_TAPS];
    logic [SW-1:0]   r_seen;
    logic [NW-1:0]   r_emit;
    logic [NW-1:0]   r_n, r_m, r_mhi;
    logic            r_last;
    logic [LW-1:0]   r_k, r_d;
    logic            r_pv;
    logic signed [PW-1:0] r_prr, r_pii, r_pri, r_pir;
    logic signed [AW-1:0] r_acc_re, r_acc_im;

    logic [8:0]      w_tc9, w_max9, w_l29;
    logic [LW-1:0]   w_l2;
    logic [NW-1:0]   w_l2e, w_start, w_end, w_mlo, w_mhi;
    logic            w_empty, w_out_fire, w_pop_load, w_pop_sample, w_last_in;
    ccs_pkg::t_cplx  w_kv, w_hv;

    // taps in use, clamped to 1..MAX_TAPS
    always_comb begin
        w_tc9  = 9'(i_tap_count);
        w_max9 = 9'(MAX_TAPS);
        if (w_tc9 == 9'd0) w_l29 = 9'd1;
        else if (w_tc9 > w_max9) w_l29 = w_max9;
        else w_l29 = w_tc9;
        w_l2  = LW'(w_l29);
        w_l2e = NW'(w_l2);
    end

    // output window of this sample
    always_comb begin
        case (i_shape_mode)
            ccs_pkg::SHAPE_SAME: begin
                w_start = w_l2e >> 1;
                w_end   = (w_l2e >> 1) + r_n;
            end
            ccs_pkg::SHAPE_VALID: begin
                w_start = w_l2e - 1'b1;
                w_end   = r_n;
            end
            default: begin
                w_start = '0;
                w_end   = r_n + w_l2e - 1'b1;
            end
        endcase
        w_mlo   = (r_n > w_start) ? r_n : w_start;
        w_mhi   = r_last ? w_end : r_n;
        w_empty = (w_mlo > w_mhi);
    end

    assign w_out_fire   = (r_state == ccs_pkg::ST_OUT) && !i_stall;
    assign w_pop_load   = o_q_pop && !i_q_item.is_sample;
    assign w_pop_sample = o_q_pop && i_q_item.is_sample;
    assign w_last_in    = i_q_item.last || (r_seen == SW'(MAX_LEN - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ccs_pkg::ST_IDLE:  if (i_q_valid && i_q_item.is_sample) n_state = ccs_pkg::ST_SETUP;
            ccs_pkg::ST_SETUP: n_state = w_empty ? ccs_pkg::ST_FIN : ccs_pkg::ST_INIT;
            ccs_pkg::ST_INIT:  n_state = ccs_pkg::ST_MAC;
            ccs_pkg::ST_MAC:   if (r_k == w_l2 - 1'b1) n_state = ccs_pkg::ST_DRAIN;
            ccs_pkg::ST_DRAIN: n_state = ccs_pkg::ST_OUT;
            ccs_pkg::ST_OUT: begin
                if (!i_stall) n_state = (r_m == r_mhi) ? ccs_pkg::ST_FIN : ccs_pkg::ST_INIT;
            end
            ccs_pkg::ST_FIN:   n_state = ccs_pkg::ST_IDLE;
            default:           n_state = ccs_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            ccs_pkg::ST_IDLE: o_q_pop = i_q_valid;
            ccs_pkg::ST_OUT:  o_valid = 1'b1;
            default: begin
                o_q_pop = 1'b0;
                o_valid = 1'b0;
            end
        endcase
    end

    assign o_out_re       = r_acc_re;
    assign o_out_im       = r_acc_im;
    assign o_out_position = ccs_pkg::POS_W'(r_emit);
    assign o_vector_done  = r_last && (r_m == r_mhi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ccs_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // kernel store and sample history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_kern[i] <= '0;
                r_hist[i] <= '0;
            end
        end else begin
            if (w_pop_load && i_q_item.tap_ok) r_kern[TW'(i_q_item.tap_index)] <= i_q_item.value;
            if (w_pop_sample) begin
                for (int i = MAX_TAPS - 1; i > 0; i--) r_hist[i] <= r_hist[i-1];
                r_hist[0] <= i_q_item.value;
            end else if (r_state == ccs_pkg::ST_FIN && r_last) begin
                for (int i = 0; i < MAX_TAPS; i++) r_hist[i] <= '0;
            end
        end
    end

    // vector counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_emit <= '0;
            r_last <= 1'b0;
            r_n    <= '0;
        end else begin
            if (w_pop_sample) begin
                r_n    <= NW'(r_seen);
                r_seen <= r_seen + 1'b1;
                r_last <= w_last_in;
            end else if (r_state == ccs_pkg::ST_FIN && r_last) begin
                r_seen <= '0;
                r_emit <= '0;
            end
            if (w_out_fire) r_emit <= r_emit + 1'b1;
        end
    end

    // output walk over the window
    always_ff @(posedge i_clk) begin
        if (r_state == ccs_pkg::ST_SETUP) begin
            r_m   <= w_mlo;
            r_mhi <= w_mhi;
        end else if (w_out_fire) begin
            r_m <= r_m + 1'b1;
        end
    end

    // tap read for the mac
    assign w_kv = r_kern[TW'(r_k)];
    assign w_hv = r_hist[TW'(r_k - r_d)];

    // product stage then accumulate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= (r_state == ccs_pkg::ST_MAC);
        end
        if (r_state == ccs_pkg::ST_INIT) begin
            r_d      <= LW'(r_m - r_n);
            r_k      <= LW'(r_m - r_n);
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else begin
            if (r_state == ccs_pkg::ST_MAC) r_k <= r_k + 1'b1;
            if (r_pv) begin
                r_acc_re <= r_acc_re + AW'(r_prr) - AW'(r_pii);
                r_acc_im <= r_acc_im + AW'(r_pri) + AW'(r_pir);
            end
        end
        r_prr <= w_hv.re * w_kv.re;
        r_pii <= w_hv.im * w_kv.im;
        r_pri <= w_hv.re * w_kv.im;
        r_pir <= w_hv.im * w_kv.re;
    end

endmodule
`default_nettype wire

### bench/tb_top.sv
// self-checking bench for the complex convolution unit: directed tests then random vectors
// depends on ccs_pkg and complex_convolution_shaped_unit
`default_nettype none
module tb_top;

    localparam int NTAPS = 32;
    localparam bit ACT_LOAD = 1'b0;
    localparam bit ACT_PUSH = 1'b1;

    typedef struct {
        bit                            action;
        bit [ccs_pkg::TAP_IDX_W-1:0]   tap_index;
        bit [ccs_pkg::SAMPLE_BITS-1:0] re;
        bit [ccs_pkg::SAMPLE_BITS-1:0] im;
        bit                            last;
        bit                            has_exp;
        bit [ccs_pkg::ACC_W-1:0]       exp_re;
        bit [ccs_pkg::ACC_W-1:0]       exp_im;
    } t_stim;

    typedef struct {
        bit [ccs_pkg::ACC_W-1:0] re;
        bit [ccs_pkg::ACC_W-1:0] im;
        bit [ccs_pkg::POS_W-1:0] pos;
        bit                      done;
    } t_conv_out;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [ccs_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [ccs_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic                            action;
    logic [ccs_pkg::TAP_IDX_W-1:0]   tap_index;
    logic [ccs_pkg::SAMPLE_BITS-1:0] value_re;
    logic [ccs_pkg::SAMPLE_BITS-1:0] value_im;
    logic                            sample_last;
    logic                            out_valid;
    logic                            out_stall;
    logic [ccs_pkg::ACC_W-1:0]       out_re;
    logic [ccs_pkg::ACC_W-1:0]       out_im;
    logic [ccs_pkg::POS_W-1:0]       out_position;
    logic                            out_vector_done;

    complex_convolution_shaped_unit i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_action(action), .i_tap_index(tap_index),
        .i_value_re(value_re), .i_value_im(value_im), .i_sample_last(sample_last),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_out_re(out_re), .o_out_im(out_im),
        .o_out_position(out_position), .o_vector_done(out_vector_done)
    );

    // predictor state
    longint    kern_re [NTAPS];
    longint    kern_im [NTAPS];
    longint    hist_re [NTAPS];
    longint    hist_im [NTAPS];
    int        n_seen;
    int        n_emitted;
    int        taps_reg;
    int        shape_reg;
    t_conv_out conv_expected[$];
    int        errors;
    int        send_idle_pct;
    int        recv_idle_pct;
    longint    cycle_count;

    // clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // cycle limit
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 2000000) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    // one convolution output at delay d from the newest sample
    function automatic t_conv_out conv_at(int d, int l2, bit done);
        t_conv_out r;
        longint sr = 0;
        longint si = 0;
        for (int k = d; k < l2; k++) begin
            sr += hist_re[k-d] * kern_re[k] - hist_im[k-d] * kern_im[k];
            si += hist_re[k-d] * kern_im[k] + hist_im[k-d] * kern_re[k];
        end
        r.re = sr[ccs_pkg::ACC_W-1:0];
        r.im = si[ccs_pkg::ACC_W-1:0];
        r.pos = n_emitted[ccs_pkg::POS_W-1:0];
        r.done = done;
        n_emitted++;
        return r;
    endfunction

    task automatic predict_conv(input t_stim s);
        int l2, n, l1, lo, hi, m;
        bit fin;
        l2 = (taps_reg < 1) ? 1 : (taps_reg > NTAPS ? NTAPS : taps_reg);
        if (s.action == ACT_LOAD) begin
            kern_re[s.tap_index] = longint'($signed(s.re));
            kern_im[s.tap_index] = longint'($signed(s.im));
            return;
        end
        for (int i = NTAPS - 1; i > 0; i--) begin
            hist_re[i] = hist_re[i-1];
            hist_im[i] = hist_im[i-1];
        end
        hist_re[0] = longint'($signed(s.re));
        hist_im[0] = longint'($signed(s.im));
        n_seen++;
        n = n_seen - 1;
        l1 = n_seen;
        fin = s.last || (n_seen >= ccs_pkg::MAX_LEN_DEF);
        if (shape_reg == ccs_pkg::SHAPE_SAME) begin
            lo = l2 / 2; hi = l2 / 2 + l1 - 1;
        end else if (shape_reg == ccs_pkg::SHAPE_VALID) begin
            lo = l2 - 1; hi = l1 - 1;
        end else begin
            lo = 0; hi = l1 + l2 - 2;
        end
        if (n >= lo && n <= hi)
            conv_expected.push_back(conv_at(0, l2, fin && n == hi));
        if (fin) begin
            m = (l1 > lo) ? l1 : lo;
            for (; m <= hi; m++)
                conv_expected.push_back(conv_at(m - n, l2, m == hi));
            for (int i = 0; i < NTAPS; i++) begin
                hist_re[i] = 0;
                hist_im[i] = 0;
            end
            n_seen = 0;
            n_emitted = 0;
        end
    endtask

    // receiver: random stall and checking
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                if (conv_expected.size() == 0) begin
                    report_mismatch("unexpected output", out_position, 0);
                end else begin
                    t_conv_out e;
                    e = conv_expected.pop_front();
                    if (out_re !== e.re) report_mismatch("out_re", out_re, e.re);
                    if (out_im !== e.im) report_mismatch("out_im", out_im, e.im);
                    if (out_position !== e.pos)
                        report_mismatch("out_position", out_position, e.pos);
                    if (out_vector_done !== e.done)
                        report_mismatch("vector_done", out_vector_done, e.done);
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // one transfer on the input channel, with a random lead-in gap
    task automatic send_item(input t_stim s);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= s.action;
        tap_index   <= s.tap_index;
        value_re    <= s.re;
        value_im    <= s.im;
        sample_last <= s.last;
        predict_conv(s);
        // typed expectation of a table row against the predicted output
        if (s.has_exp) begin
            if (conv_expected.size() == 0) begin
                report_mismatch("table row output", 0, 1);
            end else begin
                if (conv_expected[$].re != s.exp_re)
                    report_mismatch("table out_re", conv_expected[$].re, s.exp_re);
                if (conv_expected[$].im != s.exp_im)
                    report_mismatch("table out_im", conv_expected[$].im, s.exp_im);
            end
        end
        do @(posedge clk); while (in_stall);
    endtask

    // wait for every expected output, then let the block settle
    task automatic drain_outputs();
        in_valid <= 1'b0;
        while (conv_expected.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [ccs_pkg::CFG_IDX_W-1:0] idx, input int val);
        in_valid  <= 1'b0;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[ccs_pkg::CFG_DATA_W-1:0];
        if (idx == ccs_pkg::CFG_TAP_COUNT) taps_reg = val & 6'h3f;
        else shape_reg = val & 2'h3;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic t_stim mk(bit act, int ti, int re, int im, bit lst);
        t_stim s;
        s.action = act; s.tap_index = ti[ccs_pkg::TAP_IDX_W-1:0];
        s.re = re[ccs_pkg::SAMPLE_BITS-1:0]; s.im = im[ccs_pkg::SAMPLE_BITS-1:0];
        s.last = lst; s.has_exp = 1'b0; s.exp_re = '0; s.exp_im = '0;
        return s;
    endfunction

    // random value: mostly uniform over 16 bits, with the extremes -32768 and 32767 mixed in
    function automatic int rnd_val();
        case ($urandom_range(5))
            0: return -32768;
            1: return 32767;
            default: return $urandom_range(65535);
        endcase
    endfunction

    t_stim table_rows[$];
    t_stim row;
    int    items;
    int    len;

    initial begin
        errors = 0; n_seen = 0; n_emitted = 0; taps_reg = 1; shape_reg = 0;
        for (int i = 0; i < NTAPS; i++) begin
            kern_re[i] = 0; kern_im[i] = 0; hist_re[i] = 0; hist_im[i] = 0;
        end
        send_idle_pct = 38; recv_idle_pct = 52;
        rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; action = 1'b0; tap_index = '0;
        value_re = '0; value_im = '0; sample_last = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: zero kernel after reset, then extremes with one tap
        row = mk(ACT_PUSH, 0, 32767, -32768, 1);
        row.has_exp = 1'b1;
        table_rows.push_back(row);
        table_rows.push_back(mk(ACT_LOAD, 0, -32768, -32768, 1));
        row = mk(ACT_PUSH, 0, -32768, -32768, 1);
        // (-1 - 1j)^2 style: re = a*a - a*a = 0, im = 2*2^30
        row.has_exp = 1'b1; row.exp_re = '0; row.exp_im = 40'h0080000000;
        table_rows.push_back(row);
        table_rows.push_back(mk(ACT_LOAD, 31, 32767, 1, 0));
        table_rows.push_back(mk(ACT_LOAD, 5, -1, 32767, 0));
        table_rows.push_back(mk(ACT_PUSH, 3, 32767, 32767, 0));
        table_rows.push_back(mk(ACT_PUSH, 0, -32768, 1, 1));
        foreach (table_rows[i]) begin
            send_item(table_rows[i]);
            if (table_rows[i].has_exp) begin
                drain_outputs();
            end
        end
        drain_outputs();

        // full kernel, each shape, extremes of tap_count
        write_cfg(ccs_pkg::CFG_TAP_COUNT, 32);
        for (int t = 0; t < NTAPS; t++) send_item(mk(ACT_LOAD, t, rnd_val(), rnd_val(), 0));
        drain_outputs();
        for (int sh = 0; sh < 4; sh++) begin
            write_cfg(ccs_pkg::CFG_SHAPE_MODE, sh);
            for (int j = 0; j < 3; j++) send_item(mk(ACT_PUSH, 0, rnd_val(), rnd_val(), j == 2));
            drain_outputs();
        end
        write_cfg(ccs_pkg::CFG_TAP_COUNT, 0);
        write_cfg(ccs_pkg::CFG_SHAPE_MODE, ccs_pkg::SHAPE_VALID);
        send_item(mk(ACT_PUSH, 0, 32767, 32767, 1));
        drain_outputs();
        write_cfg(ccs_pkg::CFG_TAP_COUNT, 63);
        send_item(mk(ACT_PUSH, 0, -32768, 32767, 0));
        send_item(mk(ACT_PUSH, 0, 1, -1, 1));
        drain_outputs();

        // random phases
        items = 0;
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin send_idle_pct = 52; recv_idle_pct = 38; end
            if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
            while (items < 65 * (ph + 1)) begin
                drain_outputs();
                write_cfg(ccs_pkg::CFG_TAP_COUNT,
                          ($urandom_range(7) == 0) ? 32 : $urandom_range(1, 8));
                write_cfg(ccs_pkg::CFG_SHAPE_MODE, $urandom_range(3));
                for (int j = $urandom_range(3); j > 0; j--) begin
                    send_item(mk(ACT_LOAD, $urandom_range(31), rnd_val(), rnd_val(),
                                 $urandom_range(1)));
                    items++;
                end
                len = $urandom_range(1, 12);
                for (int j = 0; j < len; j++) begin
                    send_item(mk(ACT_PUSH, $urandom_range(31), rnd_val(), rnd_val(),
                                 j == len - 1));
                    items++;
                end
                if (ph == 1 && items > 90 && items < 110) drain_outputs();
            end
        end
        drain_outputs();

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
design/ccs_pkg.sv
design/ccs_front.sv
design/ccs_back.sv
design/complex_convolution_shaped_unit.sv
bench/tb_top.sv
